// File: design/tvdlfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvdlfr_pkg: shared types and constants of the TVD face reconstruction unit
// Entry format of the front-to-back queue, configuration codes and the
// signed saturation helper used by both the divider and the face datapath.
// ----------------------------------------------------------------------------
package tvdlfr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned NORM_W        = 31;

  // Limiter codes. Code 3 is unused and behaves as piecewise constant.
  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_MINMOD = 2'd1;
  localparam logic [1:0] MODE_MC     = 2'd2;

  // Register indexes (paddr bit 2).
  localparam logic REG_LIMITER = 1'b0;
  localparam logic REG_DIVIDE  = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] ratio;
    logic              flt;
    logic [NORM_W-1:0] nfp;
    logic [NORM_W-1:0] nfm;
    logic              lstart;
  } entry_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       div_en;
  } cfg_t;

  typedef struct packed {
    logic              flt;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Apply a sign to a magnitude and clamp to the 32-bit signed range.
  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.flt = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.flt = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'(~mag[31:0] + 32'd1);
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r.flt = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/tvdlfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvdlfr_front: input stage with restoring divider
// Accepts one item, forms the cell ratio (sample / norm when enabled, one
// quotient bit per cycle) and hands a queue entry to the back end.
// ----------------------------------------------------------------------------
module tvdlfr_front #(
  parameter int unsigned FRAC_BITS = tvdlfr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                div_en_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [31:0]         sample_i,
  input  wire logic [30:0]         nv_i,
  input  wire logic [30:0]         np_i,
  input  wire logic [30:0]         nm_i,
  input  wire logic                lstart_i,
  output tvdlfr_pkg::entry_t       ent_o,
  output logic                     ent_valid_o,
  input  wire logic                ent_ready_i
);
  import tvdlfr_pkg::*;

  localparam int unsigned NUM_W = 33 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_FIN} state_e;

  state_e           state_q;
  entry_t           ent_q;
  logic             ovalid_q;
  logic             neg_q;
  logic [30:0]      den_q;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quo_q;
  logic [30:0]      rem_q;
  logic [CNT_W-1:0] cnt_q;

  logic             slot_free;
  logic [31:0]      mag;
  logic [31:0]      rem_sh;
  logic             ge;
  logic [30:0]      rem_d;
  sat_t             qsat;

  assign slot_free   = !ovalid_q || ent_ready_i;
  assign in_ready_o  = (state_q == F_IDLE) && slot_free;
  assign ent_o       = ent_q;
  assign ent_valid_o = ovalid_q;

  assign mag    = sample_i[31] ? 32'(~sample_i + 32'd1) : sample_i;
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_d  = ge ? 31'(rem_sh - {1'b0, den_q}) : rem_sh[30:0];
  assign qsat   = sat_mag(neg_q, 64'(quo_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && ent_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            ent_q.nfp    <= np_i;
            ent_q.nfm    <= nm_i;
            ent_q.lstart <= lstart_i;
            if (!div_en_i) begin
              ent_q.ratio <= sample_i;
              ent_q.flt   <= 1'b0;
              ovalid_q    <= 1'b1;
            end else if (nv_i == '0) begin
              // Zero norm: clamp toward the sample's sign, zero stays zero.
              ent_q.ratio <= (sample_i == '0) ? 32'd0 :
                             (sample_i[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
              ent_q.flt   <= 1'b1;
              ovalid_q    <= 1'b1;
            end else begin
              neg_q   <= sample_i[31];
              den_q   <= nv_i;
              num_q   <= (NUM_W'(mag) << FRAC_BITS) + NUM_W'(nv_i >> 1);
              rem_q   <= '0;
              quo_q   <= '0;
              cnt_q   <= CNT_W'(NUM_W);
              state_q <= F_DIV;
            end
          end
        end
        F_DIV: begin
          rem_q <= rem_d;
          quo_q <= {quo_q[NUM_W-2:0], ge};
          num_q <= num_q << 1;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= F_FIN;
          end
        end
        F_FIN: begin
          if (slot_free) begin
            ent_q.ratio <= qsat.val;
            ent_q.flt   <= qsat.flt;
            ovalid_q    <= 1'b1;
            state_q     <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/tvdlfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvdlfr_queue: two-entry queue between front and back end
// Lets the divider run ahead while the back end works on the window.
// ----------------------------------------------------------------------------
module tvdlfr_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  tvdlfr_pkg::entry_t      push_data_i,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  output tvdlfr_pkg::entry_t      pop_data_o,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i
);
  import tvdlfr_pkg::*;

  entry_t     mem_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// File: design/tvdlfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvdlfr_back: three-cell window, limiter and face datapath
// Keeps left and centre ratios, limits the slope, forms both faces with
// saturation, optionally rescales them by the centre face norms.
// ----------------------------------------------------------------------------
module tvdlfr_back #(
  parameter int unsigned FRAC_BITS = tvdlfr_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  tvdlfr_pkg::cfg_t        cfg_i,
  input  tvdlfr_pkg::entry_t      ent_i,
  input  wire logic               ent_valid_i,
  output logic                    ent_ready_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic [31:0]             fm_o,
  output logic [31:0]             fp_o,
  output logic                    flt_o
);
  import tvdlfr_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_SLOPE, B_FACE, B_MULM, B_RNDM, B_MULP, B_RNDP, B_DONE
  } state_e;

  state_e             state_q;
  logic [31:0]        left_q;
  logic [31:0]        centre_q;
  logic [30:0]        cnp_q;
  logic [30:0]        cnm_q;
  logic [1:0]         fill_q;
  logic [1:0]         wfault_q;

  logic signed [31:0] cw_q;
  logic signed [32:0] dl_q;
  logic signed [32:0] dr_q;
  logic signed [32:0] dc_q;
  logic [30:0]        npw_q;
  logic [30:0]        nmw_q;
  logic               flt_q;
  logic               fo_q;
  logic signed [34:0] h_q;
  logic [31:0]        fm_q;
  logic [31:0]        fp_q;
  logic [62:0]        prod_q;
  logic               mvalid_q;
  logic [31:0]        ofm_q;
  logic [31:0]        ofp_q;
  logic               oflt_q;

  logic [1:0]         eff_fill;
  logic signed [34:0] la;
  logic signed [34:0] lb;
  logic signed [34:0] lc;
  logic signed [34:0] lm;
  logic [34:0]        lmag;
  logic [33:0]        hmag;
  logic signed [34:0] h_d;
  logic signed [35:0] vm;
  logic signed [35:0] vp;
  logic [35:0]        vm_mag;
  logic [35:0]        vp_mag;
  sat_t               sat_m;
  sat_t               sat_p;
  logic [31:0]        mag_m;
  logic [31:0]        mag_p;
  logic [31:0]        mul_a;
  logic [30:0]        mul_b;
  logic [62:0]        mul_p;
  logic               rnd_neg;
  sat_t               sat_r;
  logic               limited;

  assign ent_ready_o = state_q == B_IDLE;
  assign m_valid_o   = mvalid_q;
  assign fm_o        = ofm_q;
  assign fp_o        = ofp_q;
  assign flt_o       = oflt_q;
  assign eff_fill    = ent_i.lstart ? 2'd0 : fill_q;
  assign limited     = (cfg_i.mode == MODE_MINMOD) || (cfg_i.mode == MODE_MC);

  // Limiter: minmod is minmod3 with its first argument repeated.
  // MC is evaluated exactly on 4*dl, 4*dr, dc, then divided by four, rounded.
  always_comb begin
    if (cfg_i.mode == MODE_MC) begin
      la = 35'(dl_q) <<< 2;
      lb = 35'(dr_q) <<< 2;
      lc = 35'(dc_q);
    end else begin
      la = 35'(dl_q);
      lb = 35'(dr_q);
      lc = 35'(dl_q);
    end
    if (la < 0 && lb < 0 && lc < 0) begin
      lm = (la > lb) ? la : lb;
      lm = (lm > lc) ? lm : lc;
    end else if (la > 0 && lb > 0 && lc > 0) begin
      lm = (la < lb) ? la : lb;
      lm = (lm < lc) ? lm : lc;
    end else begin
      lm = '0;
    end
    lmag = lm[34] ? 35'(-lm) : 35'(lm);
    if (cfg_i.mode == MODE_MC) begin
      hmag = 34'((lmag + 35'd2) >> 2);
    end else begin
      hmag = 34'((lmag + 35'd1) >> 1);
    end
    if (!limited) begin
      h_d = '0;
    end else if (lm[34]) begin
      h_d = -$signed({1'b0, hmag});
    end else begin
      h_d = $signed({1'b0, hmag});
    end
  end

  assign vm     = 36'(cw_q) - 36'(h_q);
  assign vp     = 36'(cw_q) + 36'(h_q);
  assign vm_mag = vm[35] ? 36'(-vm) : 36'(vm);
  assign vp_mag = vp[35] ? 36'(-vp) : 36'(vp);
  assign sat_m  = sat_mag(vm[35], 64'(vm_mag));
  assign sat_p  = sat_mag(vp[35], 64'(vp_mag));

  // Shared rescale multiplier; one face per pass.
  assign mag_m   = fm_q[31] ? 32'(~fm_q + 32'd1) : fm_q;
  assign mag_p   = fp_q[31] ? 32'(~fp_q + 32'd1) : fp_q;
  assign mul_a   = (state_q == B_MULM) ? mag_m : mag_p;
  assign mul_b   = (state_q == B_MULM) ? nmw_q : npw_q;
  assign mul_p   = mul_a * mul_b;
  assign rnd_neg = (state_q == B_RNDM) ? fm_q[31] : fp_q[31];
  assign sat_r   = sat_mag(rnd_neg,
                           (64'(prod_q) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      mvalid_q <= 1'b0;
      left_q   <= '0;
      centre_q <= '0;
      cnp_q    <= '0;
      cnm_q    <= '0;
      fill_q   <= 2'd0;
      wfault_q <= 2'd0;
    end else begin
      if (mvalid_q && m_ready_i) begin
        mvalid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (ent_valid_i) begin
            if (eff_fill == 2'd2) begin
              cw_q    <= $signed(centre_q);
              dl_q    <= 33'($signed(centre_q)) - 33'($signed(left_q));
              dr_q    <= 33'($signed(ent_i.ratio)) - 33'($signed(centre_q));
              dc_q    <= 33'($signed(ent_i.ratio)) - 33'($signed(left_q));
              npw_q   <= cnp_q;
              nmw_q   <= cnm_q;
              flt_q   <= wfault_q[1];
              fo_q    <= wfault_q[0] | ent_i.flt;
              state_q <= B_SLOPE;
            end
            left_q   <= centre_q;
            centre_q <= ent_i.ratio;
            cnp_q    <= ent_i.nfp;
            cnm_q    <= ent_i.nfm;
            wfault_q <= {ent_i.flt, wfault_q[1]};
            fill_q   <= (eff_fill == 2'd2) ? 2'd2 : eff_fill + 2'd1;
          end
        end
        B_SLOPE: begin
          h_q     <= h_d;
          flt_q   <= flt_q | (limited & fo_q);
          state_q <= B_FACE;
        end
        B_FACE: begin
          fm_q    <= sat_m.val;
          fp_q    <= sat_p.val;
          flt_q   <= flt_q | sat_m.flt | sat_p.flt;
          state_q <= cfg_i.div_en ? B_MULM : B_DONE;
        end
        B_MULM: begin
          prod_q  <= mul_p;
          state_q <= B_RNDM;
        end
        B_RNDM: begin
          fm_q    <= sat_r.val;
          flt_q   <= flt_q | sat_r.flt;
          state_q <= B_MULP;
        end
        B_MULP: begin
          prod_q  <= mul_p;
          state_q <= B_RNDP;
        end
        B_RNDP: begin
          fp_q    <= sat_r.val;
          flt_q   <= flt_q | sat_r.flt;
          state_q <= B_DONE;
        end
        B_DONE: begin
          if (!mvalid_q || m_ready_i) begin
            ofm_q    <= fm_q;
            ofp_q    <= fp_q;
            oflt_q   <= flt_q;
            mvalid_q <= 1'b1;
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/tvd_limited_face_reconstruction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvd_limited_face_reconstruction_unit: TVD slope-limited face values
// Cell samples of one grid line enter on the s_axis channel; the left and
// right face values of each centre cell leave on the m_axis channel.
//
// Input item: tdata holds sample, norm_value, norm_face_plus and
// norm_face_minus; tuser flags the first cell of a new line. A result
// appears for every cell that completes a three-cell window.
// With division off the front end takes one item per cycle while the queue
// keeps taking its entries; with division on it takes no new item until its
// bit-serial divider is done. An item with a result holds the back end in
// SLOPE, FACE, with rescaling MULM, RNDM, MULP, RNDP (one 32x31 multiplier,
// used twice), and DONE until its result is registered; other items leave
// it idle. A two-entry queue decouples the two ends; a stalled receiver holds
// the output register, then the back end, then the queue and finally tready.
// Reset empties the window and sets limiter_mode to minmod, divide off.
// Configuration is written through the APB port; the user must write it
// only while the unit is idle, which the unit itself does not enforce.
// ----------------------------------------------------------------------------
module tvd_limited_face_reconstruction_unit #(
  parameter int unsigned FRAC_BITS = tvdlfr_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] sample, [62:32] norm_value, [93:63] norm_face_plus,
  // [124:94] norm_face_minus, [127:125] zero
  input  wire logic [127:0] s_axis_tdata,
  // [0] line_start
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] face_minus, [63:32] face_plus
  output logic [63:0]       m_axis_tdata,
  // [0] fault
  output logic              m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tvdlfr_pkg::*;

  logic [1:0] limiter_mode_q;
  logic       divide_by_norm_q;
  cfg_t       cfg;
  logic       cfg_wr;

  entry_t     f_ent;
  logic       f_valid;
  logic       f_ready;
  entry_t     q_ent;
  logic       q_valid;
  logic       q_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DIVIDE) ? {31'd0, divide_by_norm_q}
                                           : {30'd0, limiter_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limiter_mode_q   <= MODE_MINMOD;
      divide_by_norm_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LIMITER: limiter_mode_q   <= pwdata[1:0];
        REG_DIVIDE:  divide_by_norm_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.mode   = limiter_mode_q;
  assign cfg.div_en = divide_by_norm_q;

  tvdlfr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .div_en_i    (divide_by_norm_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata[31:0]),
    .nv_i        (s_axis_tdata[62:32]),
    .np_i        (s_axis_tdata[93:63]),
    .nm_i        (s_axis_tdata[124:94]),
    .lstart_i    (s_axis_tuser),
    .ent_o       (f_ent),
    .ent_valid_o (f_valid),
    .ent_ready_i (f_ready)
  );

  tvdlfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_ent),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_ent),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  tvdlfr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ent_i       (q_ent),
    .ent_valid_i (q_valid),
    .ent_ready_o (q_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .fm_o        (m_axis_tdata[31:0]),
    .fp_o        (m_axis_tdata[63:32]),
    .flt_o       (m_axis_tuser)
  );

  // A register write lands in the addressed register on the next edge.
  a_cfg_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (paddr[2] == REG_LIMITER) |=> limiter_mode_q == $past(pwdata[1:0]))
    else $error("limiter mode write lost");

  // An entry offered to the full queue is held until taken.
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && !f_ready |=> f_valid && $stable(f_ent))
    else $error("front entry dropped while queue full");

  // A queued entry is kept until the back end takes it.
  a_queue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !q_ready |=> q_valid && $stable(q_ent))
    else $error("queue entry lost before pop");

endmodule
`default_nettype wire

// File: dv/tvd_face_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvd_face_checker: predicts and checks the face values of the TVD unit
// Watches the input and output streams and the register port, keeps its
// own copy of the three-cell window and compares every result in order.
// ----------------------------------------------------------------------------
module tvd_face_checker #(
  parameter int unsigned FRAC_BITS = tvdlfr_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [63:0]  m_axis_tdata,
  input  wire logic         m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  input  wire logic         pready,
  output int                fail_count,
  output int                faces_pending
);
  import tvdlfr_pkg::*;

  typedef struct packed {
    logic [31:0] fm;
    logic [31:0] fp;
    logic        flt;
  } faces_t;

  faces_t      face_queue[$];
  logic [1:0]  mode_q;
  logic        div_q;
  longint      left_r, centre_r;
  longint      cfp, cfm;
  int          fill;
  logic [1:0]  wflt;

  localparam longint PMAX = 64'sd2147483647;
  localparam longint NMIN = -64'sd2147483648;

  function automatic longint clamp32(input longint v, inout logic f);
    if (v > PMAX) begin
      f = 1'b1;
      return PMAX;
    end
    if (v < NMIN) begin
      f = 1'b1;
      return NMIN;
    end
    return v;
  endfunction

  function automatic longint abs64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint norm_divide(input longint s, input longint n, inout logic f);
    longint m;
    if (n == 0) begin
      f = 1'b1;
      return s == 0 ? 0 : (s < 0 ? NMIN : PMAX);
    end
    m = ((abs64(s) << FRAC_BITS) + (n >> 1)) / n;
    return clamp32(s < 0 ? -m : m, f);
  endfunction

  function automatic longint face_rescale(input longint v, input longint n, inout logic f);
    logic [63:0] m;
    m = 64'(abs64(v)) * 64'(n);
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (v < 0) return (m > 64'h8000_0000) ? clamp32(NMIN - 1, f) : -longint'(m);
    return (m > 64'h7FFF_FFFF) ? clamp32(PMAX + 1, f) : longint'(m);
  endfunction

  function automatic longint half_round(input longint v, input int sh);
    longint m;
    m = (abs64(v) + (64'sd1 << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint minmod2(input longint a, input longint b);
    if (a < 0 && b < 0) return a > b ? a : b;
    if (a > 0 && b > 0) return a < b ? a : b;
    return 0;
  endfunction

  function automatic longint minmod3(input longint a, input longint b, input longint c);
    return minmod2(minmod2(a, b), c) == 0 ? 0 :
           ((a < 0 && b < 0 && c < 0) || (a > 0 && b > 0 && c > 0)) ?
           minmod2(minmod2(a, b), c) : 0;
  endfunction

  task automatic predict_faces(input logic [127:0] d, input logic ls);
    longint s, r, h, fm, fp, dl, dr, dc;
    logic nf, f;
    faces_t e;
    s  = longint'($signed(d[31:0]));
    nf = 1'b0;
    if (ls) fill = 0;
    r = div_q ? norm_divide(s, longint'(d[62:32]), nf) : s;
    if (fill >= 2) begin
      dl = centre_r - left_r;
      dr = r - centre_r;
      dc = r - left_r;
      h  = 0;
      f  = wflt[1];
      if (mode_q == MODE_MINMOD) h = half_round(minmod2(dl, dr), 1);
      else if (mode_q == MODE_MC) h = half_round(minmod3(4 * dl, 4 * dr, dc), 2);
      if (mode_q == MODE_MINMOD || mode_q == MODE_MC) f = f | wflt[0] | nf;
      fm = clamp32(centre_r - h, f);
      fp = clamp32(centre_r + h, f);
      if (div_q) begin
        fm = face_rescale(fm, cfm, f);
        fp = face_rescale(fp, cfp, f);
      end
      e.fm  = fm[31:0];
      e.fp  = fp[31:0];
      e.flt = f;
      face_queue.push_back(e);
    end
    left_r   = centre_r;
    centre_r = r;
    cfp      = longint'(d[93:63]);
    cfm      = longint'(d[124:94]);
    wflt     = {nf, wflt[1]};
    if (fill < 2) fill++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    faces_t e;
    if (!rst_ni) begin
      mode_q   <= MODE_MINMOD;
      div_q    <= 1'b0;
      left_r   = 0;
      centre_r = 0;
      cfp      = 0;
      cfm      = 0;
      fill     = 0;
      wflt     = 2'b00;
      fail_count = 0;
      face_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (face_queue.size() == 0) begin
          $display("%0t: unexpected result, actual fm=%h fp=%h fault=%b", $time,
                   m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
          fail_count++;
        end else begin
          e = face_queue.pop_front();
          if (e.fm !== m_axis_tdata[31:0]) begin
            $display("%0t: face_minus expected %h actual %h", $time, e.fm,
                     m_axis_tdata[31:0]);
            fail_count++;
          end
          if (e.fp !== m_axis_tdata[63:32]) begin
            $display("%0t: face_plus expected %h actual %h", $time, e.fp,
                     m_axis_tdata[63:32]);
            fail_count++;
          end
          if (e.flt !== m_axis_tuser) begin
            $display("%0t: fault expected %b actual %b", $time, e.flt, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_faces(s_axis_tdata, s_axis_tuser);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LIMITER) mode_q <= pwdata[1:0];
        else div_q <= pwdata[0];
      end
    end
  end

  assign faces_pending = face_queue.size();

endmodule

// File: dv/tvd_limited_face_reconstruction_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvd_limited_face_reconstruction_unit_tb: stimulus for the TVD face unit
// Runs directed extremes and random grid lines under every limiter and
// divide setting, with random idling on both streams and one long output
// stall; the checker decides on each result.
// ----------------------------------------------------------------------------
module tvd_limited_face_reconstruction_unit_tb;
  import tvdlfr_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count, faces_pending;
  bit           calm = 1'b0;
  bit           hold_off = 1'b0;

  tvd_limited_face_reconstruction_unit dut (.*);
  tvd_face_checker chk (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // Output side: random stall bursts, except when told to hold or keep calm.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_cell(input logic [31:0] smp, input logic [30:0] nv,
                           input logic [30:0] np, input logic [30:0] nm,
                           input logic first);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, nm, np, nv, smp};
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    while (faces_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65535) << 8;
      3: return -($urandom_range(0, 65535) << 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_norm();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'h0001_0000;
      default: return 31'($urandom_range(16'h4000, 20'h3FFFF));
    endcase
  endfunction

  task automatic random_lines(input int cells);
    int len, k;
    k = 0;
    while (k < cells) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      for (int j = 0; j < len && k < cells; j++, k++)
        send_cell(rand_sample(), rand_norm(), rand_norm(), rand_norm(), j == 0);
    end
  endtask

  initial begin
    logic [1:0] modes [6] = '{MODE_CONST, MODE_MINMOD, MODE_MC, 2'd3, MODE_MC, MODE_MINMOD};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, zero norms, sign changes, short lines, all modes.
    for (int m = 0; m < 3; m++) begin
      write_reg({REG_LIMITER, 2'b00}, 32'(m) | 32'hFFFF_FFFC);
      write_reg({REG_DIVIDE, 2'b00}, m == 2 ? 32'hFFFF_FFFF : 32'h0);
      send_cell(32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, 1'b1);
      send_cell(32'h7FFF_FFFF, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      send_cell(32'h8000_0000, 31'h1, '0, 31'h7FFF_FFFF, 1'b0);
      send_cell(32'h0, '0, 31'h10000, 31'h10000, 1'b0);
      send_cell(32'h0001_0000, 31'h10000, 31'h10000, 31'h10000, 1'b0);
      send_cell(32'h0003_0001, 31'h10000, 31'h10000, 31'h10000, 1'b1);
      send_cell(32'h0000_0003, 31'h10000, 31'h10000, 31'h10000, 1'b0);
      drain_idle();
    end

    for (int p = 0; p < 6; p++) begin
      write_reg({REG_LIMITER, 2'b00}, 32'(modes[p]));
      write_reg({REG_DIVIDE, 2'b00}, 32'(p % 2));
      if (p == 2) fork
        begin
          hold_off = 1'b1;
          repeat (300) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
      if (p == 5) calm = 1'b1;
      random_lines(140);
      drain_idle();
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
design/tvdlfr_pkg.sv
design/tvdlfr_front.sv
design/tvdlfr_queue.sv
design/tvdlfr_back.sv
design/tvd_limited_face_reconstruction_unit.sv
dv/tvd_face_checker.sv
dv/tvd_limited_face_reconstruction_unit_tb.sv
